// ===== hdl/llwd_pkg.sv =====
package llwd_pkg;

   // Worker table geometry
   localparam int PORTS = 12;
   localparam int IDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;
   localparam int CNT_W = $clog2(PORTS + 1);

   // Field widths fixed by the interface
   localparam int FUNC_W  = 3;
   localparam int PORT_W  = 4;
   localparam int TIME_W  = 32;
   localparam int QUEUE_W = 8;
   localparam int KHZ_W   = 19;
   localparam int KIND_W  = 2;

   localparam logic [QUEUE_W-1:0] QUEUE_LIMIT = 8'hFF;

   // Event codes
   localparam logic [FUNC_W-1:0] FUNC_PROBE_OK   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PROBE_FAIL = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_RESULT     = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_STATUS     = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_OTHER      = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_DISPATCH   = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SWEEP      = 3'd6;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_GRANTED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DROP    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

   // Register map (word index = byte address / 4)
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_MAX_CLOCK    = 2'd0;
   localparam logic [1:0] REG_IDLE_CLOCK   = 2'd1;
   localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd2;

   localparam logic [KHZ_W-1:0]  MAX_CLOCK_RESET    = 19'd250000;
   localparam logic [KHZ_W-1:0]  IDLE_CLOCK_RESET   = 19'd12000;
   localparam logic [TIME_W-1:0] IDLE_TIMEOUT_RESET = 32'd1000000;

   typedef struct packed {
      logic               alive;
      logic               busy;
      logic [QUEUE_W-1:0] queue;
      logic [TIME_W-1:0]  seen_us;
      logic [KHZ_W-1:0]   set_khz;
   } entry_type;

endpackage

// ===== hdl/least_loaded_worker_dispatcher.sv =====
// Least-loaded worker dispatcher. Keeps one table entry per worker port
// (alive, busy, queue depth, last-seen time, commanded clock) in a small
// synchronous RAM and updates it from events on the req_ channel. Port
// events (probe ok/fail, result, status, other packet) give no result;
// each is accepted, its entry is read and then written back. A dispatch
// or an idle sweep walks the table with one RAM read per cycle, but a
// sweep holds its walk while a further drop is ready, an earlier drop
// word is held back and the output register still holds an untaken word.
// A dispatch gives exactly one word (granted or refused); a sweep gives
// one clock-drop word per dropped port in ascending order, or one "none
// found" word, with rsp_last on the final word. Events for ports at or
// above PORTS and func code 7 are taken and dropped silently. The table
// reads as all zero after reset through per-entry valid bits, so no
// clearing pass is needed. Registers live at byte addresses 0 (max clock),
// 4 (idle clock) and 8 (idle timeout). The user must write them only while
// the block is idle; the block itself does not enforce this.
module least_loaded_worker_dispatcher (
   input  logic                          clock,
   input  logic                          reset,
   // Event channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [llwd_pkg::FUNC_W-1:0]   req_func,
   input  logic [llwd_pkg::PORT_W-1:0]   req_port,
   input  logic [llwd_pkg::TIME_W-1:0]   req_now_us,
   input  logic                          req_status_valid,
   input  logic                          req_worker_busy,
   input  logic [llwd_pkg::QUEUE_W-1:0]  req_queue_level,
   // Result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [llwd_pkg::KIND_W-1:0]   rsp_kind,
   output logic [llwd_pkg::PORT_W-1:0]   rsp_chosen_port,
   output logic                          rsp_clock_raised,
   output logic [llwd_pkg::KHZ_W-1:0]    rsp_command_khz,
   output logic                          rsp_last,
   // Register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [llwd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_MODIFY,
      S_SCAN,
      S_FINAL
   } state_type;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   logic [llwd_pkg::KHZ_W-1:0]  max_clock_ff;
   logic [llwd_pkg::KHZ_W-1:0]  idle_clock_ff;
   logic [llwd_pkg::TIME_W-1:0] idle_timeout_ff;
   logic [1:0]                  csr_index;
   logic                        csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_clock_ff    <= llwd_pkg::MAX_CLOCK_RESET;
         idle_clock_ff   <= llwd_pkg::IDLE_CLOCK_RESET;
         idle_timeout_ff <= llwd_pkg::IDLE_TIMEOUT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            llwd_pkg::REG_MAX_CLOCK: begin
               max_clock_ff <= csr_pwdata[llwd_pkg::KHZ_W-1:0];
            end
            llwd_pkg::REG_IDLE_CLOCK: begin
               idle_clock_ff <= csr_pwdata[llwd_pkg::KHZ_W-1:0];
            end
            llwd_pkg::REG_IDLE_TIMEOUT: begin
               idle_timeout_ff <= csr_pwdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         llwd_pkg::REG_MAX_CLOCK:    csr_prdata = 32'(max_clock_ff);
         llwd_pkg::REG_IDLE_CLOCK:   csr_prdata = 32'(idle_clock_ff);
         llwd_pkg::REG_IDLE_TIMEOUT: csr_prdata = idle_timeout_ff;
         default:                    csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Port table RAM: one read and one write port, registered read data.
   // A per-entry valid bit makes never-written entries read as zero.
   // ---------------------------------------------------------------------
   llwd_pkg::entry_type         port_ram [llwd_pkg::PORTS];
   logic [llwd_pkg::PORTS-1:0]  entry_vld_ff;
   llwd_pkg::entry_type         rd_data_ff;
   logic                        rd_hit_ff;
   logic                        rd_en;
   logic [llwd_pkg::IDX_W-1:0]  rd_addr;
   logic                        wr_en;
   logic [llwd_pkg::IDX_W-1:0]  wr_addr;
   llwd_pkg::entry_type         wr_data;
   llwd_pkg::entry_type         ent;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         port_ram[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= port_ram[rd_addr];
         rd_hit_ff  <= entry_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= '0;
      end else if (wr_en) begin
         entry_vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign ent = rd_hit_ff ? rd_data_ff : '0;

   // ---------------------------------------------------------------------
   // Sequencer and datapath
   // ---------------------------------------------------------------------
   state_type                     state_ff, state_in;
   logic [llwd_pkg::FUNC_W-1:0]   op_func_ff, op_func_in;
   logic [llwd_pkg::IDX_W-1:0]    op_idx_ff, op_idx_in;
   logic [llwd_pkg::TIME_W-1:0]   op_now_ff, op_now_in;
   logic                          op_sv_ff, op_sv_in;
   logic                          op_wb_ff, op_wb_in;
   logic [llwd_pkg::QUEUE_W-1:0]  op_ql_ff, op_ql_in;
   logic [llwd_pkg::CNT_W-1:0]    scan_ff, scan_in;
   logic                          eval_vld_ff, eval_vld_in;
   logic [llwd_pkg::IDX_W-1:0]    eval_idx_ff, eval_idx_in;
   logic                          found_ff, found_in;
   logic [llwd_pkg::IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [llwd_pkg::QUEUE_W-1:0]  best_q_ff, best_q_in;
   llwd_pkg::entry_type           best_ent_ff, best_ent_in;
   logic                          pend_vld_ff, pend_vld_in;
   logic [llwd_pkg::IDX_W-1:0]    pend_idx_ff, pend_idx_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [llwd_pkg::KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [llwd_pkg::PORT_W-1:0]   rsp_port_ff, rsp_port_in;
   logic                          rsp_raised_ff, rsp_raised_in;
   logic [llwd_pkg::KHZ_W-1:0]    rsp_khz_ff, rsp_khz_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          req_accept;
   logic                          port_ok;
   logic                          out_free;
   logic                          issue;
   logic [llwd_pkg::IDX_W-1:0]    scan_idx;
   logic [llwd_pkg::TIME_W-1:0]   silent;
   logic                          drop;
   logic                          cand;
   logic                          hold_scan;
   logic                          raise;
   llwd_pkg::entry_type           event_ent;
   llwd_pkg::entry_type           drop_ent;
   llwd_pkg::entry_type           grant_ent;

   logic                          out_load;
   logic [llwd_pkg::KIND_W-1:0]   out_kind;
   logic [llwd_pkg::IDX_W-1:0]    out_idx;
   logic                          out_raised;
   logic [llwd_pkg::KHZ_W-1:0]    out_khz;
   logic                          out_last;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign port_ok    = (32'(req_port) < 32'(llwd_pkg::PORTS));
   // Output register is free when empty or being drained this cycle
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   assign issue    = (scan_ff < llwd_pkg::CNT_W'(llwd_pkg::PORTS));
   assign scan_idx = scan_ff[llwd_pkg::IDX_W-1:0];

   // Candidate tests on the entry that the RAM returned this cycle
   assign silent = op_now_ff - ent.seen_us;
   assign drop   = ent.alive & ~ent.busy & (silent > idle_timeout_ff)
                   & (ent.set_khz > idle_clock_ff);
   assign cand   = ent.alive & ~ent.busy & (ent.queue < best_q_ff);
   // A second drop cannot proceed until the held one has somewhere to go
   assign hold_scan = eval_vld_ff & (op_func_ff == llwd_pkg::FUNC_SWEEP) & drop
                      & pend_vld_ff & ~out_free;
   assign raise     = best_ent_ff.set_khz < max_clock_ff;

   always_comb begin
      drop_ent         = ent;
      drop_ent.set_khz = idle_clock_ff;

      grant_ent      = best_ent_ff;
      grant_ent.busy = 1'b1;
      if (raise) begin
         grant_ent.set_khz = max_clock_ff;
      end

      event_ent = ent;
      case (op_func_ff)
         llwd_pkg::FUNC_PROBE_OK: begin
            event_ent.alive   = 1'b1;
            event_ent.seen_us = op_now_ff;
            if (ent.set_khz == '0) begin
               event_ent.set_khz = max_clock_ff;
            end
            if (op_sv_ff) begin
               event_ent.busy  = op_wb_ff;
               event_ent.queue = op_ql_ff;
            end
         end
         llwd_pkg::FUNC_PROBE_FAIL: begin
            event_ent.alive = 1'b0;
         end
         llwd_pkg::FUNC_RESULT: begin
            event_ent.alive   = 1'b1;
            event_ent.seen_us = op_now_ff;
            event_ent.busy    = 1'b0;
         end
         llwd_pkg::FUNC_STATUS: begin
            event_ent.alive   = 1'b1;
            event_ent.seen_us = op_now_ff;
            if (op_sv_ff) begin
               event_ent.busy  = op_wb_ff;
               event_ent.queue = op_ql_ff;
            end
         end
         llwd_pkg::FUNC_OTHER: begin
            event_ent.alive   = 1'b1;
            event_ent.seen_us = op_now_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      op_func_in  = op_func_ff;
      op_idx_in   = op_idx_ff;
      op_now_in   = op_now_ff;
      op_sv_in    = op_sv_ff;
      op_wb_in    = op_wb_ff;
      op_ql_in    = op_ql_ff;
      scan_in     = scan_ff;
      eval_vld_in = eval_vld_ff;
      eval_idx_in = eval_idx_ff;
      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      best_q_in   = best_q_ff;
      best_ent_in = best_ent_ff;
      pend_vld_in = pend_vld_ff;
      pend_idx_in = pend_idx_ff;

      rd_en   = 1'b0;
      rd_addr = scan_idx;
      wr_en   = 1'b0;
      wr_addr = eval_idx_ff;
      wr_data = drop_ent;

      out_load   = 1'b0;
      out_kind   = llwd_pkg::KIND_NONE;
      out_idx    = '0;
      out_raised = 1'b0;
      out_khz    = '0;
      out_last   = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_func_in = req_func;
               op_idx_in  = llwd_pkg::IDX_W'(req_port);
               op_now_in  = req_now_us;
               op_sv_in   = req_status_valid;
               op_wb_in   = req_worker_busy;
               op_ql_in   = req_queue_level;
               scan_in     = '0;
               eval_vld_in = 1'b0;
               found_in    = 1'b0;
               best_q_in   = llwd_pkg::QUEUE_LIMIT;
               pend_vld_in = 1'b0;
               if (req_func <= llwd_pkg::FUNC_OTHER) begin
                  if (port_ok) begin
                     state_in = S_READ;
                  end
               end else if (req_func == llwd_pkg::FUNC_DISPATCH ||
                            req_func == llwd_pkg::FUNC_SWEEP) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            rd_addr  = op_idx_ff;
            state_in = S_MODIFY;
         end
         S_MODIFY: begin
            wr_en    = 1'b1;
            wr_addr  = op_idx_ff;
            wr_data  = event_ent;
            state_in = S_IDLE;
         end
         S_SCAN: begin
            if (!hold_scan) begin
               // Read the next entry while judging the previous one
               rd_en       = issue;
               eval_vld_in = issue;
               eval_idx_in = scan_idx;
               if (issue) begin
                  scan_in = scan_ff + 1'b1;
               end else begin
                  state_in = S_FINAL;
               end
               if (eval_vld_ff) begin
                  if (op_func_ff == llwd_pkg::FUNC_DISPATCH) begin
                     if (cand) begin
                        found_in    = 1'b1;
                        best_idx_in = eval_idx_ff;
                        best_q_in   = ent.queue;
                        best_ent_in = ent;
                     end
                  end else if (drop) begin
                     wr_en = 1'b1;
                     // Hold each drop back one step so the final one can carry last
                     if (pend_vld_ff) begin
                        out_load = 1'b1;
                        out_kind = llwd_pkg::KIND_DROP;
                        out_idx  = pend_idx_ff;
                        out_khz  = idle_clock_ff;
                        out_last = 1'b0;
                     end
                     pend_vld_in = 1'b1;
                     pend_idx_in = eval_idx_ff;
                  end
               end
            end
         end
         S_FINAL: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
               if (op_func_ff == llwd_pkg::FUNC_DISPATCH) begin
                  if (found_ff) begin
                     wr_en      = 1'b1;
                     wr_addr    = best_idx_ff;
                     wr_data    = grant_ent;
                     out_kind   = llwd_pkg::KIND_GRANTED;
                     out_idx    = best_idx_ff;
                     out_raised = raise;
                     out_khz    = raise ? max_clock_ff : '0;
                  end else begin
                     out_kind = llwd_pkg::KIND_REFUSED;
                  end
               end else if (pend_vld_ff) begin
                  out_kind = llwd_pkg::KIND_DROP;
                  out_idx  = pend_idx_ff;
                  out_khz  = idle_clock_ff;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Output register: load a new word, else drain when taken
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_port_in   = rsp_port_ff;
      rsp_raised_in = rsp_raised_ff;
      rsp_khz_in    = rsp_khz_ff;
      rsp_last_in   = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = out_kind;
         rsp_port_in   = llwd_pkg::PORT_W'(out_idx);
         rsp_raised_in = out_raised;
         rsp_khz_in    = out_khz;
         rsp_last_in   = out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         eval_vld_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         eval_vld_ff  <= eval_vld_in;
         pend_vld_ff  <= pend_vld_in;
         found_ff     <= found_in;
      end
      op_func_ff    <= op_func_in;
      op_idx_ff     <= op_idx_in;
      op_now_ff     <= op_now_in;
      op_sv_ff      <= op_sv_in;
      op_wb_ff      <= op_wb_in;
      op_ql_ff      <= op_ql_in;
      scan_ff       <= scan_in;
      eval_idx_ff   <= eval_idx_in;
      best_idx_ff   <= best_idx_in;
      best_q_ff     <= best_q_in;
      best_ent_ff   <= best_ent_in;
      pend_idx_ff   <= pend_idx_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_raised_ff <= rsp_raised_in;
      rsp_khz_ff    <= rsp_khz_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_chosen_port  = rsp_port_ff;
   assign rsp_clock_raised = rsp_raised_ff;
   assign rsp_command_khz  = rsp_khz_ff;
   assign rsp_last         = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff != S_IDLE))
      else $error("table write while idle");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result word overwritten before it was taken");

   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_func == llwd_pkg::FUNC_DISPATCH ||
                      req_func == llwd_pkg::FUNC_SWEEP))
      |=> (state_ff == S_SCAN && scan_ff == '0))
      else $error("dispatch or sweep did not start a table walk");

   a_dispatch_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == llwd_pkg::KIND_REFUSED ||
                     rsp_kind == llwd_pkg::KIND_GRANTED)) |-> rsp_last)
      else $error("dispatch word without last");

endmodule
